### rtl/core/dbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode package
// Shared widths, register indexes, record field positions and the structs
// that pass configuration, control and results between the modules.
// ----------------------------------------------------------------------------
package dbd_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS           = 16;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int THRESHOLD_WIDTH     = 17;
   localparam int CLASS_WIDTH         = 8;
   localparam int COORD_WIDTH         = 32;
   localparam int POS_WIDTH           = 9;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCORE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLASS_COUNT     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_SCALE       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_OFFSET_X    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_OFFSET_Y    = 3'd4;

   // register reset values
   localparam logic [THRESHOLD_WIDTH-1:0] RST_SCORE_THRESHOLD = 17'd16384;
   localparam logic [CLASS_WIDTH-1:0]     RST_CLASS_COUNT     = 8'd80;
   localparam logic [COORD_WIDTH-1:0]     RST_MAP_SCALE       = 32'd65536;
   localparam logic [COORD_WIDTH-1:0]     RST_MAP_OFFSET      = 32'd0;

   // field positions within a record
   localparam logic [POS_WIDTH-1:0] FLD_CENTRE_X    = 9'd0;
   localparam logic [POS_WIDTH-1:0] FLD_CENTRE_Y    = 9'd1;
   localparam logic [POS_WIDTH-1:0] FLD_BOX_WIDTH   = 9'd2;
   localparam logic [POS_WIDTH-1:0] FLD_BOX_HEIGHT  = 9'd3;
   localparam logic [POS_WIDTH-1:0] FLD_OBJECTNESS  = 9'd4;
   localparam logic [POS_WIDTH-1:0] FLD_FIRST_SCORE = 9'd5;

   // confidence limits: 1.0 for the result, all ones for the threshold compare
   localparam logic [THRESHOLD_WIDTH-1:0] CONF_MAX  = 17'h1_0000;
   localparam logic [THRESHOLD_WIDTH-1:0] SCORE_SAT = 17'h1_FFFF;

   typedef struct packed {
      logic [THRESHOLD_WIDTH-1:0] score_threshold;
      logic [CLASS_WIDTH-1:0]     class_count;
      logic [COORD_WIDTH-1:0]     map_scale;
      logic [COORD_WIDTH-1:0]     map_offset_x;
      logic [COORD_WIDTH-1:0]     map_offset_y;
   } dbd_cfg_type;

   typedef struct packed {
      logic                   record_end;
      logic                   image_end;
      logic                   obj_pass;
      logic [CLASS_WIDTH-1:0] label;
   } dbd_ctrl_type;

   typedef struct packed {
      logic                       box_valid;
      logic                       image_done;
      logic [COORD_WIDTH-1:0]     left;
      logic [COORD_WIDTH-1:0]     top;
      logic [COORD_WIDTH-1:0]     right;
      logic [COORD_WIDTH-1:0]     bottom;
      logic [CLASS_WIDTH-1:0]     class_label;
      logic [THRESHOLD_WIDTH-1:0] confidence;
   } dbd_result_type;

endpackage

### rtl/core/dbd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode configuration registers
// Holds threshold, class count, scale and offsets; one write per cycle.
// ----------------------------------------------------------------------------
module dbd_csr
   import dbd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output dbd_cfg_type                cfg
);

   dbd_cfg_type cfg_ff;
   dbd_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCORE_THRESHOLD: cfg_in.score_threshold = csr_data[THRESHOLD_WIDTH-1:0];
            CSR_CLASS_COUNT:     cfg_in.class_count     = csr_data[CLASS_WIDTH-1:0];
            CSR_MAP_SCALE:       cfg_in.map_scale       = csr_data[COORD_WIDTH-1:0];
            CSR_MAP_OFFSET_X:    cfg_in.map_offset_x    = csr_data[COORD_WIDTH-1:0];
            CSR_MAP_OFFSET_Y:    cfg_in.map_offset_y    = csr_data[COORD_WIDTH-1:0];
            default:             cfg_in = cfg_ff;  // ignore unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold <= RST_SCORE_THRESHOLD;
         cfg_ff.class_count     <= RST_CLASS_COUNT;
         cfg_ff.map_scale       <= RST_MAP_SCALE;
         cfg_ff.map_offset_x    <= RST_MAP_OFFSET;
         cfg_ff.map_offset_y    <= RST_MAP_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/dbd_field_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode field tracker
// Counts fields of a record, holds the box fields and keeps the running
// argmax over class scores; hands a snapshot on at record or image end.
// ----------------------------------------------------------------------------
module dbd_field_tracker
   import dbd_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic [CLASS_WIDTH-1:0]        class_count,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [VALUE_WIDTH-1:0] in_value,
   input  logic                          in_end_of_image,
   output logic                          tok_valid,
   input  logic                          tok_ready,
   output dbd_ctrl_type                  tok_ctrl,
   output logic signed [VALUE_WIDTH-1:0] tok_centre_x,
   output logic signed [VALUE_WIDTH-1:0] tok_centre_y,
   output logic signed [VALUE_WIDTH-1:0] tok_box_width,
   output logic signed [VALUE_WIDTH-1:0] tok_box_height,
   output logic signed [VALUE_WIDTH-1:0] tok_objectness,
   output logic signed [VALUE_WIDTH-1:0] tok_best_score
);

   logic [POS_WIDTH-1:0]          pos_ff, pos_in;
   logic signed [VALUE_WIDTH-1:0] centre_x_ff, centre_x_in;
   logic signed [VALUE_WIDTH-1:0] centre_y_ff, centre_y_in;
   logic signed [VALUE_WIDTH-1:0] width_ff, width_in;
   logic signed [VALUE_WIDTH-1:0] height_ff, height_in;
   logic signed [VALUE_WIDTH-1:0] obj_ff, obj_in;
   logic signed [VALUE_WIDTH-1:0] best_ff, best_in;
   logic [CLASS_WIDTH-1:0]        best_idx_ff, best_idx_in;

   logic [CLASS_WIDTH-1:0] count_eff;
   logic [POS_WIDTH-1:0]   last_pos;
   logic [POS_WIDTH-1:0]   pos_cur;
   logic                   at_last;
   logic                   accept;

   assign in_ready  = tok_ready;
   assign accept    = in_valid && in_ready;

   // a zero count acts as one; clamp a position left beyond a lowered count
   assign count_eff = (class_count == '0) ? CLASS_WIDTH'(1) : class_count;
   assign last_pos  = FLD_OBJECTNESS + POS_WIDTH'(count_eff);
   assign pos_cur   = (pos_ff > last_pos) ? last_pos : pos_ff;
   assign at_last   = (pos_cur == last_pos);

   always_comb begin
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      obj_in      = obj_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      unique case (pos_cur)
         FLD_CENTRE_X:   centre_x_in = in_value;
         FLD_CENTRE_Y:   centre_y_in = in_value;
         FLD_BOX_WIDTH:  width_in    = in_value;
         FLD_BOX_HEIGHT: height_in   = in_value;
         FLD_OBJECTNESS: obj_in      = in_value;
         FLD_FIRST_SCORE: begin
            best_in     = in_value;
            best_idx_in = '0;
         end
         default: begin
            // strict compare: the first maximum keeps its index
            if (in_value > best_ff) begin
               best_in     = in_value;
               best_idx_in = CLASS_WIDTH'(pos_cur - FLD_FIRST_SCORE);
            end
         end
      endcase
      pos_in = (at_last || in_end_of_image) ? '0 : pos_cur + POS_WIDTH'(1);
   end

   assign tok_valid           = in_valid && (at_last || in_end_of_image);
   assign tok_ctrl.record_end = at_last;
   assign tok_ctrl.image_end  = in_end_of_image;
   assign tok_ctrl.obj_pass   = 1'b0;
   assign tok_ctrl.label      = best_idx_in;
   assign tok_centre_x        = centre_x_ff;
   assign tok_centre_y        = centre_y_ff;
   assign tok_box_width       = width_ff;
   assign tok_box_height      = height_ff;
   assign tok_objectness      = obj_ff;
   assign tok_best_score      = best_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         centre_x_ff <= centre_x_in;
         centre_y_ff <= centre_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         obj_ff      <= obj_in;
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
      end
   end

endmodule

### rtl/core/dbd_box_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode arithmetic pipeline
// Four stages: input snapshot, corner sums and score clamps, split partial
// products, product assembly; then offset add, saturation, threshold decision.
// ----------------------------------------------------------------------------
module dbd_box_pipe
   import dbd_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   input  dbd_cfg_type                   cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  dbd_ctrl_type                  in_ctrl,
   input  logic signed [VALUE_WIDTH-1:0] in_centre_x,
   input  logic signed [VALUE_WIDTH-1:0] in_centre_y,
   input  logic signed [VALUE_WIDTH-1:0] in_box_width,
   input  logic signed [VALUE_WIDTH-1:0] in_box_height,
   input  logic signed [VALUE_WIDTH-1:0] in_objectness,
   input  logic signed [VALUE_WIDTH-1:0] in_best_score,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          out_emit,
   output dbd_result_type                out_result
);

   localparam int PIPE_STAGES = 4;
   localparam int TW       = VALUE_WIDTH + 2;          // 2*centre +/- size
   localparam int LO_W     = (TW + 1) / 2;
   localparam int HI_W     = TW - LO_W;
   localparam int PW       = TW + COORD_WIDTH + 1;     // full scaled product
   localparam int QW       = PW - (FRAC_BITS + 1);     // after the halving shift
   localparam int SW       = QW + 1;
   localparam int SAT_BIT  = THRESHOLD_WIDTH + FRAC_BITS;
   localparam int OPW      = SAT_BIT + 1;
   localparam int OP_SPLIT = OPW / 2;
   localparam int SLW      = OPW + OP_SPLIT;
   localparam int SHW      = OPW + (OPW - OP_SPLIT);
   localparam int SPW      = 2 * OPW;
   localparam int XW       = (VALUE_WIDTH > OPW) ? VALUE_WIDTH : OPW + 1;
   localparam logic signed [XW-1:0] OP_CAP = XW'(1) << SAT_BIT;
   localparam logic signed [SW-1:0] COORD_HI = SW'(32'sh7FFF_FFFF);
   localparam logic signed [SW-1:0] COORD_LO = SW'(32'sh8000_0000);

   logic [PIPE_STAGES-1:0] stage_valid_ff;
   logic [PIPE_STAGES-1:0] stage_load;

   // stage 1: snapshot
   dbd_ctrl_type                  s1_ctrl_ff;
   logic signed [VALUE_WIDTH-1:0] s1_cx_ff, s1_cy_ff, s1_w_ff, s1_h_ff;
   logic signed [VALUE_WIDTH-1:0] s1_obj_ff, s1_best_ff;
   // stage 2: corner sums and clamped score operands
   dbd_ctrl_type                  s2_ctrl_ff, s2_ctrl_in;
   logic signed [TW-1:0]          s2_twice_ff [4];
   logic signed [TW-1:0]          s2_twice_in [4];
   logic [OPW-1:0]                s2_objc_ff, s2_objc_in;
   logic [OPW-1:0]                s2_bestc_ff, s2_bestc_in;
   // stage 3: partial products
   dbd_ctrl_type                  s3_ctrl_ff;
   logic signed [HI_W+COORD_WIDTH:0] s3_ph_ff [4];
   logic signed [HI_W+COORD_WIDTH:0] s3_ph_in [4];
   logic [LO_W+COORD_WIDTH-1:0]   s3_pl_ff [4];
   logic [LO_W+COORD_WIDTH-1:0]   s3_pl_in [4];
   logic [SHW-1:0]                s3_sh_ff, s3_sh_in;
   logic [SLW-1:0]                s3_sl_ff, s3_sl_in;
   // stage 4: assembled products
   dbd_ctrl_type                  s4_ctrl_ff;
   logic signed [QW-1:0]          s4_q_ff [4];
   logic signed [QW-1:0]          s4_q_in [4];
   logic [THRESHOLD_WIDTH-1:0]    s4_csat_ff, s4_csat_in;

   logic signed [XW-1:0]          obj_x, best_x, thr_x;
   logic signed [PW-1:0]          prod [4];
   logic [SPW-1:0]                score_prod;
   logic signed [SW-1:0]          coord_sum [4];
   logic [COORD_WIDTH-1:0]        corner [4];
   logic                          box_ok;

   // a stage takes new contents when empty or when its contents move on
   always_comb begin
      stage_load[PIPE_STAGES-1] = !stage_valid_ff[PIPE_STAGES-1] || out_ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         stage_load[k] = !stage_valid_ff[k] || stage_load[k+1];
      end
   end

   assign in_ready  = stage_load[0];
   assign out_valid = stage_valid_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         if (stage_load[0]) begin
            stage_valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < PIPE_STAGES; k++) begin
            if (stage_load[k]) begin
               stage_valid_ff[k] <= stage_valid_ff[k-1];
            end
         end
      end
   end

   // stage 1 -> 2
   always_comb begin
      s2_twice_in[0] = (TW'(s1_cx_ff) <<< 1) - TW'(s1_w_ff);
      s2_twice_in[1] = (TW'(s1_cy_ff) <<< 1) - TW'(s1_h_ff);
      s2_twice_in[2] = (TW'(s1_cx_ff) <<< 1) + TW'(s1_w_ff);
      s2_twice_in[3] = (TW'(s1_cy_ff) <<< 1) + TW'(s1_h_ff);

      obj_x  = XW'(s1_obj_ff);
      best_x = XW'(s1_best_ff);
      thr_x  = $signed(XW'(cfg.score_threshold));

      // clamp at 2^33: any larger operand saturates the score anyway
      s2_objc_in  = obj_x[XW-1] ? '0 :
                    (obj_x >= OP_CAP) ? OPW'(OP_CAP) : OPW'(obj_x);
      s2_bestc_in = best_x[XW-1] ? '0 :
                    (best_x >= OP_CAP) ? OPW'(OP_CAP) : OPW'(best_x);

      s2_ctrl_in          = s1_ctrl_ff;
      s2_ctrl_in.obj_pass = (obj_x >= thr_x) &&
                            !((obj_x > 0) && best_x[XW-1]);
   end

   // stage 2 -> 3
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s3_ph_in[k] = $signed(s2_twice_ff[k][TW-1:LO_W]) * $signed({1'b0, cfg.map_scale});
         s3_pl_in[k] = s2_twice_ff[k][LO_W-1:0] * cfg.map_scale;
      end
      s3_sl_in = s2_objc_ff * s2_bestc_ff[OP_SPLIT-1:0];
      s3_sh_in = s2_objc_ff * s2_bestc_ff[OPW-1:OP_SPLIT];
   end

   // stage 3 -> 4; the arithmetic shift floors the halved product
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod[k]    = (PW'(s3_ph_ff[k]) <<< LO_W) + PW'(s3_pl_ff[k]);
         s4_q_in[k] = prod[k][PW-1:FRAC_BITS+1];
      end
      score_prod = (SPW'(s3_sh_ff) << OP_SPLIT) + SPW'(s3_sl_ff);
      s4_csat_in = (|score_prod[SPW-1:SAT_BIT]) ? SCORE_SAT
                                                : score_prod[SAT_BIT-1:FRAC_BITS];
   end

   // stage 4 -> result
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         // odd corners are vertical
         coord_sum[k] = SW'(s4_q_ff[k]) +
                        SW'($signed(k[0] ? cfg.map_offset_y : cfg.map_offset_x));
         if (coord_sum[k] > COORD_HI) begin
            corner[k] = COORD_HI[COORD_WIDTH-1:0];
         end else if (coord_sum[k] < COORD_LO) begin
            corner[k] = COORD_LO[COORD_WIDTH-1:0];
         end else begin
            corner[k] = coord_sum[k][COORD_WIDTH-1:0];
         end
      end

      box_ok = s4_ctrl_ff.record_end && s4_ctrl_ff.obj_pass &&
               (s4_csat_ff >= cfg.score_threshold);

      out_result.box_valid   = box_ok;
      out_result.image_done  = s4_ctrl_ff.image_end;
      out_result.left        = box_ok ? corner[0] : '0;
      out_result.top         = box_ok ? corner[1] : '0;
      out_result.right       = box_ok ? corner[2] : '0;
      out_result.bottom      = box_ok ? corner[3] : '0;
      out_result.class_label = box_ok ? s4_ctrl_ff.label : '0;
      out_result.confidence  = !box_ok ? '0 :
                               (s4_csat_ff > CONF_MAX) ? CONF_MAX : s4_csat_ff;
      out_emit = box_ok || s4_ctrl_ff.image_end;
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         s1_ctrl_ff <= in_ctrl;
         s1_cx_ff   <= in_centre_x;
         s1_cy_ff   <= in_centre_y;
         s1_w_ff    <= in_box_width;
         s1_h_ff    <= in_box_height;
         s1_obj_ff  <= in_objectness;
         s1_best_ff <= in_best_score;
      end
      if (stage_load[1]) begin
         s2_ctrl_ff  <= s2_ctrl_in;
         s2_twice_ff <= s2_twice_in;
         s2_objc_ff  <= s2_objc_in;
         s2_bestc_ff <= s2_bestc_in;
      end
      if (stage_load[2]) begin
         s3_ctrl_ff <= s2_ctrl_ff;
         s3_ph_ff   <= s3_ph_in;
         s3_pl_ff   <= s3_pl_in;
         s3_sh_ff   <= s3_sh_in;
         s3_sl_ff   <= s3_sl_in;
      end
      if (stage_load[3]) begin
         s4_ctrl_ff <= s3_ctrl_ff;
         s4_q_ff    <= s4_q_in;
         s4_csat_ff <= s4_csat_in;
      end
   end

endmodule

### rtl/core/detection_box_decode_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode, top level
// Turns a stream of detector output values into scored, mapped corner boxes.
// ----------------------------------------------------------------------------
// Feed one signed Q16.16 value per item on req_: each record is centre x,
// centre y, width, height, objectness and then class_count class scores, with
// req_end_of_image set on the last score of an image (set earlier, it drops
// the partial record and closes the image). The block takes one item every
// cycle for as long as the result side keeps up; a record that yields no box
// costs no result slot, and the input keeps flowing while a finished result
// waits on rsp_, until four more record closings fill the pipeline behind
// it. At a record's last score the best class (first maximum wins)
// is combined with objectness; when both reach score_threshold a box is sent
// whose corners are scale*(2*centre -/+ size)/2 + offset, floored once and
// saturated to 32 bits. A result passes the four-stage arithmetic pipeline
// (input snapshot, corner sums, split partial products, product assembly),
// then the offset add and saturation into the result register. Write the
// csr_ registers only while no item is in flight; they are registered first.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module detection_box_decode_top
   import dbd_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)(
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [VALUE_WIDTH-1:0]     req_value,
   input  logic                              req_end_of_image,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_box_valid,
   output logic                              rsp_image_done,
   output logic signed [COORD_WIDTH-1:0]     rsp_left,
   output logic signed [COORD_WIDTH-1:0]     rsp_top,
   output logic signed [COORD_WIDTH-1:0]     rsp_right,
   output logic signed [COORD_WIDTH-1:0]     rsp_bottom,
   output logic [CLASS_WIDTH-1:0]            rsp_class_label,
   output logic [THRESHOLD_WIDTH-1:0]        rsp_confidence,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_data
);

   dbd_cfg_type    cfg;

   logic                          tok_valid;
   logic                          tok_ready;
   dbd_ctrl_type                  tok_ctrl;
   logic signed [VALUE_WIDTH-1:0] tok_centre_x, tok_centre_y;
   logic signed [VALUE_WIDTH-1:0] tok_box_width, tok_box_height;
   logic signed [VALUE_WIDTH-1:0] tok_objectness, tok_best_score;

   logic           pipe_valid;
   logic           pipe_ready;
   logic           pipe_emit;
   dbd_result_type pipe_result;

   logic           rsp_valid_ff, rsp_valid_in;
   dbd_result_type rsp_result_ff;
   logic           out_load;

   dbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // position counter, held box fields and running argmax
   dbd_field_tracker #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_tracker (
      .clock           (clock),
      .reset           (reset),
      .class_count     (cfg.class_count),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_value        (req_value),
      .in_end_of_image (req_end_of_image),
      .tok_valid       (tok_valid),
      .tok_ready       (tok_ready),
      .tok_ctrl        (tok_ctrl),
      .tok_centre_x    (tok_centre_x),
      .tok_centre_y    (tok_centre_y),
      .tok_box_width   (tok_box_width),
      .tok_box_height  (tok_box_height),
      .tok_objectness  (tok_objectness),
      .tok_best_score  (tok_best_score)
   );

   // record and image closings run through the arithmetic pipeline
   dbd_box_pipe #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_pipe (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (tok_valid),
      .in_ready      (tok_ready),
      .in_ctrl       (tok_ctrl),
      .in_centre_x   (tok_centre_x),
      .in_centre_y   (tok_centre_y),
      .in_box_width  (tok_box_width),
      .in_box_height (tok_box_height),
      .in_objectness (tok_objectness),
      .in_best_score (tok_best_score),
      .out_valid     (pipe_valid),
      .out_ready     (pipe_ready),
      .out_emit      (pipe_emit),
      .out_result    (pipe_result)
   );

   // Result register. Load it when it is empty or being taken; drop a
   // closed record that passed no threshold without occupying the slot.
   assign out_load     = !rsp_valid_ff || rsp_ready;
   assign pipe_ready   = out_load || !pipe_emit;
   assign rsp_valid_in = out_load ? (pipe_valid && pipe_emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold while a result waits
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_result_ff <= pipe_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_valid   = rsp_result_ff.box_valid;
   assign rsp_image_done  = rsp_result_ff.image_done;
   assign rsp_left        = rsp_result_ff.left;
   assign rsp_top         = rsp_result_ff.top;
   assign rsp_right       = rsp_result_ff.right;
   assign rsp_bottom      = rsp_result_ff.bottom;
   assign rsp_class_label = rsp_result_ff.class_label;
   assign rsp_confidence  = rsp_result_ff.confidence;

endmodule

### rtl/core/dbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection box decode port checker
// Watches the result port for holding, empty results and reset behaviour.
// ----------------------------------------------------------------------------
module dbd_checker
   import dbd_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_box_valid,
   input logic                       rsp_image_done,
   input logic [COORD_WIDTH-1:0]     rsp_left,
   input logic [COORD_WIDTH-1:0]     rsp_top,
   input logic [COORD_WIDTH-1:0]     rsp_right,
   input logic [COORD_WIDTH-1:0]     rsp_bottom,
   input logic [CLASS_WIDTH-1:0]     rsp_class_label,
   input logic [THRESHOLD_WIDTH-1:0] rsp_confidence
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_box_valid) &&
      $stable(rsp_image_done) && $stable(rsp_left) && $stable(rsp_top) &&
      $stable(rsp_right) && $stable(rsp_bottom) && $stable(rsp_class_label) &&
      $stable(rsp_confidence))
      else $error("result changed while stalled");

   // an image closing without a box carries zero box fields
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_box_valid |-> rsp_left == '0 && rsp_top == '0 &&
      rsp_right == '0 && rsp_bottom == '0 && rsp_class_label == '0 &&
      rsp_confidence == '0)
      else $error("non-zero box fields without a box");

   // every result carries a box or closes an image
   a_no_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_box_valid || rsp_image_done)
      else $error("result with neither box nor image end");

   // first edge out of reset shows no result
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind detection_box_decode_top dbd_checker u_dbd_checker (.*);
